@@ rtl/core/hps_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hps_pkg: shared types and constants for the heading PID steering block
// Fixed-point widths, register indexes, command codes and sequencer states.
// ---------------------------------------------------------------------------
package hps_pkg;

	localparam int FRAC_BITS  = 6;
	localparam int HEAD_W     = 15;
	localparam int ERR_W      = 18;
	localparam int GAIN_W     = 16;
	localparam int DB_W       = 11;
	localparam int POSE_W     = 4;
	localparam int CMD_W      = 4;
	localparam int SPEED_W    = 5;
	localparam int OUT_W      = 32;
	localparam int DIVIDEND_W = GAIN_W + 8;
	localparam int DIVISOR_W  = GAIN_W;
	localparam int COEF_W     = DIVIDEND_W + 2;
	localparam int MUL_A_W    = COEF_W + 1;
	localparam int PROD_W     = MUL_A_W + ERR_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int CFG_IDX_W  = 3;

	localparam logic signed [HEAD_W-1:0] TARG_WRAP_LIM = HEAD_W'(-(175 <<< FRAC_BITS));
	localparam logic signed [HEAD_W-1:0] MEAS_WRAP_LIM = HEAD_W'(120 << FRAC_BITS);
	localparam logic signed [HEAD_W+1:0] WRAP_SPAN     = (HEAD_W + 2)'(360 << FRAC_BITS);
	localparam logic signed [ERR_W-1:0]  TURN_LIM      = ERR_W'(3 << FRAC_BITS);

	localparam logic [SPEED_W-1:0] SPEED_MIN   = SPEED_W'(5);
	localparam logic [SPEED_W-1:0] SPEED_MAX   = SPEED_W'(20);
	localparam logic [SPEED_W-1:0] SPEED_TURN  = SPEED_W'(10);
	localparam logic [SPEED_W-1:0] SPEED_SIDE  = SPEED_W'(8);

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd4;

	localparam logic [GAIN_W-1:0] GAIN_P_RST   = 16'd2560;
	localparam logic [GAIN_W-1:0] GAIN_I_RST   = 16'd0;
	localparam logic [GAIN_W-1:0] GAIN_D_RST   = 16'd51200;
	localparam logic [GAIN_W-1:0] PERIOD_RST   = 16'd256;
	localparam logic [DB_W-1:0]   DEADBAND_RST = 11'd192;

	localparam logic [POSE_W-1:0] POSE_STOP  = 4'd0;
	localparam logic [POSE_W-1:0] POSE_FWD   = 4'd1;
	localparam logic [POSE_W-1:0] POSE_BACK  = 4'd2;
	localparam logic [POSE_W-1:0] POSE_LEFT  = 4'd4;
	localparam logic [POSE_W-1:0] POSE_RIGHT = 4'd8;

	localparam logic [CMD_W-1:0] CMD_NONE   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_STOP   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_FWD    = 4'd2;
	localparam logic [CMD_W-1:0] CMD_BACK   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_LEFT   = 4'd4;
	localparam logic [CMD_W-1:0] CMD_RIGHT  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_TURNL  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_TURNR  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_FWDL   = 4'd8;
	localparam logic [CMD_W-1:0] CMD_FWDR   = 4'd9;
	localparam logic [CMD_W-1:0] CMD_BACKL  = 4'd10;
	localparam logic [CMD_W-1:0] CMD_BACKR  = 4'd11;
	localparam logic [CMD_W-1:0] CMD_LEFTL  = 4'd12;
	localparam logic [CMD_W-1:0] CMD_LEFTR  = 4'd13;
	localparam logic [CMD_W-1:0] CMD_RIGHTL = 4'd14;
	localparam logic [CMD_W-1:0] CMD_RIGHTR = 4'd15;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_COEF,
		S_M0,
		S_M1,
		S_M2,
		S_SUM,
		S_UPD,
		S_STEER,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

@@ rtl/core/hps_divider.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// hps_divider: unsigned restoring divider
// One quotient bit per cycle; done pulses when the quotient is final.
// ---------------------------------------------------------------------------
module hps_divider #(
	parameter int DIVIDEND_W = hps_pkg::DIVIDEND_W,
	parameter int DIVISOR_W  = hps_pkg::DIVISOR_W
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       done,
	output logic [DIVIDEND_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W+1:0]  diff;

	assign rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DIVISOR_W+1]) begin
				rem_q <= diff[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ rtl/core/heading_pid_steering.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// heading_pid_steering: heading-hold steering with an incremental PID
// Sequence: inside the deadband a beat goes from S_EVAL straight to S_DONE; a PID
//   step first runs the serial divider and the four passes of the one shared
//   27x18 multiplier.
// Only one beat is in flight at a time; the next beat is taken while a result waits.
// Reset: registers to their reset values, PID output and previous errors to zero.
// ---------------------------------------------------------------------------
module heading_pid_steering (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [hps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [hps_pkg::GAIN_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [hps_pkg::HEAD_W-1:0] measured_heading,
	input  wire logic signed [hps_pkg::HEAD_W-1:0] target_heading,
	input  wire logic [hps_pkg::POSE_W-1:0]        pose,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [hps_pkg::CMD_W-1:0]              command,
	output logic [hps_pkg::SPEED_W-1:0]            speed,
	output logic                                   corrected
);

	localparam int HW = hps_pkg::HEAD_W;
	localparam int EW = hps_pkg::ERR_W;
	localparam int CW = hps_pkg::COEF_W;
	localparam int AW = hps_pkg::MUL_A_W;
	localparam int PW = hps_pkg::PROD_W;
	localparam int QW = hps_pkg::ACC_W;
	localparam int OW = hps_pkg::OUT_W;
	localparam int GW = hps_pkg::GAIN_W;
	localparam int DW = hps_pkg::DIVIDEND_W;
	localparam int SW = hps_pkg::SPEED_W;
	localparam int CMW = hps_pkg::CMD_W;
	localparam int SUM_W = QW - 8 + 1;

	hps_pkg::state_t state_q, state_d;

	logic [GW-1:0]              gain_p_q, gain_i_q, gain_d_q, period_q;
	logic [hps_pkg::DB_W-1:0]   deadband_q;

	logic signed [HW-1:0]       meas_q, targ_q;
	logic [hps_pkg::POSE_W-1:0] pose_q;

	logic signed [EW-1:0] e_q, ep_q, ep2_q;
	logic signed [OW-1:0] last_q;
	logic [CW-1:0]        a0_q, a1_q;
	logic signed [PW-1:0] prod_q;
	logic signed [QW-1:0] acc_q;

	logic [CMW-1:0] res_cmd_q;
	logic [SW-1:0]  res_speed_q;
	logic           res_corr_q;

	logic           out_valid_q;
	logic [CMW-1:0] command_q;
	logic [SW-1:0]  speed_q;
	logic           corrected_q;

	// control
	logic in_band;
	logic div_start;
	logic div_done;
	logic out_free;
	logic [DW-1:0] a2;

	// datapath
	logic signed [HW:0]   raw;
	logic [HW:0]          abs_raw;
	logic signed [HW+1:0] meas_x;
	logic signed [EW-1:0] e_new;
	logic [GW-1:0]        period_eff;
	logic signed [AW-1:0] mul_a;
	logic signed [EW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic signed [SUM_W-1:0] out_sum;
	logic signed [OW-1:0] out_sat;
	logic [OW-1:0]        mag;
	logic [OW-1:0]        mag_sh;
	logic [SW-1:0]        s_base;
	logic signed [EW-1:0] db_s;
	logic [CMW-1:0]       plain_cmd;
	logic [CMW-1:0]       steer_cmd;
	logic [SW-1:0]        steer_speed;

	assign period_eff = (period_q == '0) ? GW'(1) : period_q;

	hps_divider #(
		.DIVIDEND_W(hps_pkg::DIVIDEND_W),
		.DIVISOR_W (hps_pkg::DIVISOR_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({gain_d_q, 8'h00}),
		.divisor (period_eff),
		.done    (div_done),
		.quotient(a2)
	);

	// deadband test and heading unwrap
	assign raw     = (HW + 1)'(meas_q) - (HW + 1)'(targ_q);
	assign abs_raw = raw[HW] ? $unsigned(-raw) : $unsigned(raw);
	assign in_band = abs_raw < (HW + 1)'(deadband_q);

	always_comb begin
		if (targ_q < hps_pkg::TARG_WRAP_LIM && meas_q > hps_pkg::MEAS_WRAP_LIM) begin
			meas_x = (HW + 2)'(meas_q) - hps_pkg::WRAP_SPAN;
		end else begin
			meas_x = (HW + 2)'(meas_q);
		end
		e_new = EW'(meas_x) - EW'(targ_q);
	end

	always_comb begin
		case (pose_q)
			hps_pkg::POSE_STOP:  plain_cmd = hps_pkg::CMD_STOP;
			hps_pkg::POSE_FWD:   plain_cmd = hps_pkg::CMD_FWD;
			hps_pkg::POSE_BACK:  plain_cmd = hps_pkg::CMD_BACK;
			hps_pkg::POSE_LEFT:  plain_cmd = hps_pkg::CMD_LEFT;
			hps_pkg::POSE_RIGHT: plain_cmd = hps_pkg::CMD_RIGHT;
			default:             plain_cmd = hps_pkg::CMD_NONE;
		endcase
	end

	// shared multiplier
	always_comb begin
		case (state_q)
			hps_pkg::S_EVAL: begin
				mul_a = AW'(gain_i_q);
				mul_b = EW'(period_eff);
			end
			hps_pkg::S_M0: begin
				mul_a = AW'(a0_q);
				mul_b = e_q;
			end
			hps_pkg::S_M1: begin
				mul_a = AW'(a1_q);
				mul_b = ep_q;
			end
			hps_pkg::S_M2: begin
				mul_a = AW'(a2);
				mul_b = ep2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	// output update with saturation
	assign out_sum = SUM_W'(last_q) + SUM_W'($signed(acc_q[QW-1:8]));

	always_comb begin
		if (out_sum > SUM_W'(signed'({1'b0, {(OW-1){1'b1}}}))) begin
			out_sat = {1'b0, {(OW-1){1'b1}}};
		end else if (out_sum < SUM_W'(signed'({1'b1, {(OW-1){1'b0}}}))) begin
			out_sat = {1'b1, {(OW-1){1'b0}}};
		end else begin
			out_sat = out_sum[OW-1:0];
		end
	end

	// steering
	assign mag    = last_q[OW-1] ? (OW'(0) - $unsigned(last_q)) : $unsigned(last_q);
	assign mag_sh = mag >> hps_pkg::FRAC_BITS;
	assign db_s   = $signed(EW'(deadband_q));

	always_comb begin
		if (mag_sh < OW'(hps_pkg::SPEED_MIN)) begin
			s_base = hps_pkg::SPEED_MIN;
		end else if (mag_sh > OW'(hps_pkg::SPEED_MAX)) begin
			s_base = hps_pkg::SPEED_MAX;
		end else begin
			s_base = mag_sh[SW-1:0];
		end
	end

	always_comb begin
		steer_cmd   = hps_pkg::CMD_NONE;
		steer_speed = '0;
		case (pose_q)
			hps_pkg::POSE_STOP: begin
				if (e_q > hps_pkg::TURN_LIM) begin
					steer_cmd   = hps_pkg::CMD_TURNR;
					steer_speed = s_base + hps_pkg::SPEED_TURN;
				end else if (e_q < -hps_pkg::TURN_LIM) begin
					steer_cmd   = hps_pkg::CMD_TURNL;
					steer_speed = s_base + hps_pkg::SPEED_TURN;
				end
			end
			hps_pkg::POSE_FWD: begin
				if (e_q > db_s) begin
					steer_cmd   = hps_pkg::CMD_FWDR;
					steer_speed = s_base;
				end else if (e_q < -db_s) begin
					steer_cmd   = hps_pkg::CMD_FWDL;
					steer_speed = s_base;
				end
			end
			hps_pkg::POSE_BACK: begin
				if (e_q > db_s) begin
					steer_cmd   = hps_pkg::CMD_BACKL;
					steer_speed = s_base;
				end else if (e_q < -db_s) begin
					steer_cmd   = hps_pkg::CMD_BACKR;
					steer_speed = s_base;
				end
			end
			hps_pkg::POSE_LEFT: begin
				if (e_q > db_s) begin
					steer_cmd   = hps_pkg::CMD_LEFTL;
					steer_speed = s_base;
				end else if (e_q < -db_s) begin
					steer_cmd   = hps_pkg::CMD_LEFTR;
					steer_speed = s_base + hps_pkg::SPEED_SIDE;
				end
			end
			hps_pkg::POSE_RIGHT: begin
				if (e_q > db_s) begin
					steer_cmd   = hps_pkg::CMD_RIGHTL;
					steer_speed = s_base + hps_pkg::SPEED_SIDE;
				end else if (e_q < -db_s) begin
					steer_cmd   = hps_pkg::CMD_RIGHTR;
					steer_speed = s_base;
				end
			end
			default: begin
				steer_cmd   = hps_pkg::CMD_NONE;
				steer_speed = '0;
			end
		endcase
	end

	// sequencer
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hps_pkg::S_IDLE:  if (in_valid) state_d = hps_pkg::S_EVAL;
			hps_pkg::S_EVAL:  state_d = in_band ? hps_pkg::S_DONE : hps_pkg::S_DIV;
			hps_pkg::S_DIV:   if (div_done) state_d = hps_pkg::S_COEF;
			hps_pkg::S_COEF:  state_d = hps_pkg::S_M0;
			hps_pkg::S_M0:    state_d = hps_pkg::S_M1;
			hps_pkg::S_M1:    state_d = hps_pkg::S_M2;
			hps_pkg::S_M2:    state_d = hps_pkg::S_SUM;
			hps_pkg::S_SUM:   state_d = hps_pkg::S_UPD;
			hps_pkg::S_UPD:   state_d = hps_pkg::S_STEER;
			hps_pkg::S_STEER: state_d = hps_pkg::S_DONE;
			hps_pkg::S_DONE:  if (out_free) state_d = hps_pkg::S_IDLE;
			default:          state_d = hps_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == hps_pkg::S_IDLE);
		div_start = (state_q == hps_pkg::S_EVAL) && !in_band;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hps_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= hps_pkg::GAIN_P_RST;
			gain_i_q   <= hps_pkg::GAIN_I_RST;
			gain_d_q   <= hps_pkg::GAIN_D_RST;
			period_q   <= hps_pkg::PERIOD_RST;
			deadband_q <= hps_pkg::DEADBAND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hps_pkg::REG_GAIN_P:   gain_p_q   <= cfg_data;
				hps_pkg::REG_GAIN_I:   gain_i_q   <= cfg_data;
				hps_pkg::REG_GAIN_D:   gain_d_q   <= cfg_data;
				hps_pkg::REG_PERIOD:   period_q   <= cfg_data;
				hps_pkg::REG_DEADBAND: deadband_q <= cfg_data[hps_pkg::DB_W-1:0];
				default: ;
			endcase
		end
	end

	// PID state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			ep_q   <= '0;
			ep2_q  <= '0;
		end else if (state_q == hps_pkg::S_UPD) begin
			last_q <= out_sat;
			ep_q   <= e_q;
			ep2_q  <= ep_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			meas_q <= measured_heading;
			targ_q <= target_heading;
			pose_q <= pose;
		end
		case (state_q)
			hps_pkg::S_EVAL: begin
				e_q         <= e_new;
				prod_q      <= prod;
				res_cmd_q   <= plain_cmd;
				res_speed_q <= '0;
				res_corr_q  <= 1'b0;
			end
			hps_pkg::S_COEF: begin
				a0_q <= CW'(gain_p_q) + CW'(prod_q[DW+7:8]) + CW'(a2);
				a1_q <= CW'(gain_p_q) + CW'({a2, 1'b0});
			end
			hps_pkg::S_M0: prod_q <= prod;
			hps_pkg::S_M1: begin
				acc_q  <= QW'(prod_q);
				prod_q <= prod;
			end
			hps_pkg::S_M2: begin
				acc_q  <= acc_q - QW'(prod_q);
				prod_q <= prod;
			end
			hps_pkg::S_SUM: acc_q <= acc_q + QW'(prod_q);
			hps_pkg::S_STEER: begin
				res_cmd_q   <= steer_cmd;
				res_speed_q <= steer_speed;
				res_corr_q  <= 1'b1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == hps_pkg::S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == hps_pkg::S_DONE && out_free) begin
			command_q   <= res_cmd_q;
			speed_q     <= res_speed_q;
			corrected_q <= res_corr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign command   = command_q;
	assign speed     = speed_q;
	assign corrected = corrected_q;

endmodule
`default_nettype wire
